[design/bffc_pkg.sv]
// shared types and constants of the barometric fifo frame compensator
// no dependencies
package bffc_pkg;

	localparam int OUT_FRAC_BITS_DEF = 16;
	localparam int READING_LIMIT_DEF = 1024;

	// common denominator exponent of the pressure sum
	localparam int DEN_BITS = 181;
	localparam int ACC_W    = 256;
	localparam int CAL_W    = 168;
	localparam int TL_W     = 61;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	localparam int HDR_TEMP  = 4;
	localparam int HDR_PRESS = 2;

	localparam int          PRESS_DIV = 100;
	localparam logic [26:0] PRESS_MAX = 27'h7FFFFFF;
	localparam logic [23:0] TEMP_MAX  = 24'h7FFFFF;
	localparam logic [23:0] TEMP_MIN  = 24'h800000;
	localparam logic [10:0] MAX_READINGS_RST = 11'd80;

	typedef enum logic [1:0] {
		CFG_CAL_LO,
		CFG_CAL_MID,
		CFG_CAL_HI,
		CFG_MAX_READINGS
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] fifo_byte;
		logic       last_byte;
	} fifo_item_t;

	typedef struct packed {
		logic              reading_valid;
		logic signed [23:0] temperature_q16;
		logic [26:0]       pressure_q16;
		logic [9:0]        reading_index;
		logic              burst_end;
		logic [10:0]       reading_total;
	} res_item_t;

	typedef struct packed {
		logic        comp;
		logic [23:0] raw_temp;
		logic [23:0] raw_press;
		logic [9:0]  index;
		logic        burst_end;
		logic [10:0] total;
	} job_t;

endpackage

[design/bffc_front.sv]
// frame parser: takes fifo bytes, gathers raw values and issues jobs
// depends on bffc_pkg
module bffc_front import bffc_pkg::*; #(
	parameter int READING_LIMIT = READING_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  fifo_item_t  item,
	input  logic        take,
	input  logic [10:0] max_readings,
	output logic        push,
	output job_t        job
);

	typedef enum logic [2:0] {
		PH_HDR, PH_T0, PH_T1, PH_T2, PH_P0, PH_P1, PH_P2
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [1:0]  fl_q, fl_d;
	logic [23:0] rt_q, rt_d, rp_q, rp_d;
	logic [10:0] rd_q, rd_d;
	logic        done, rdg, below;
	logic [7:0]  b;

	assign b     = item.fifo_byte;
	assign below = (rd_q < max_readings) && (32'(rd_q) < READING_LIMIT);

	always_comb begin
		ph_d = ph_q;
		fl_d = fl_q;
		rt_d = rt_q;
		rp_d = rp_q;
		done = 1'b0;
		unique case (ph_q)
			PH_HDR: begin
				if (!item.last_byte && below) begin
					fl_d = {b[HDR_PRESS], b[HDR_TEMP]};
					rt_d = '0;
					rp_d = '0;
					if (b[HDR_TEMP]) ph_d = PH_T0;
					else if (b[HDR_PRESS]) ph_d = PH_P0;
					else done = 1'b1;
				end
			end
			PH_T0: begin
				rt_d[7:0] = b;
				ph_d = PH_T1;
			end
			PH_T1: begin
				rt_d[15:8] = b;
				ph_d = PH_T2;
			end
			PH_T2: begin
				rt_d[23:16] = b;
				if (fl_q[1]) ph_d = PH_P0;
				else done = 1'b1;
			end
			PH_P0: begin
				rp_d[7:0] = b;
				ph_d = PH_P1;
			end
			PH_P1: begin
				rp_d[15:8] = b;
				ph_d = PH_P2;
			end
			PH_P2: begin
				rp_d[23:16] = b;
				done = 1'b1;
			end
			default: ph_d = PH_HDR;
		endcase
		if (done) ph_d = PH_HDR;
		rdg  = done && ((rt_d | rp_d) != '0);
		rd_d = rd_q + 11'(rdg);
	end

	assign push           = take && (rdg || item.last_byte);
	assign job.comp       = rdg;
	assign job.raw_temp   = rt_d;
	assign job.raw_press  = rp_d;
	assign job.index      = rdg ? rd_q[9:0] : '0;
	assign job.burst_end  = item.last_byte;
	assign job.total      = item.last_byte ? rd_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HDR;
			fl_q <= '0;
			rt_q <= '0;
			rp_q <= '0;
			rd_q <= '0;
		end else if (take) begin
			if (item.last_byte) begin
				ph_q <= PH_HDR;
				fl_q <= '0;
				rt_q <= '0;
				rp_q <= '0;
				rd_q <= '0;
			end else begin
				ph_q <= ph_d;
				fl_q <= fl_d;
				rt_q <= rt_d;
				rp_q <= rp_d;
				rd_q <= rd_d;
			end
		end
	end

endmodule

[design/bffc_queue.sv]
// short job queue between the frame parser and the compensation engine
// depends on bffc_pkg
module bffc_queue import bffc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	input  logic pop,
	output job_t job_out,
	output logic not_empty,
	output logic full
);

	job_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign job_out   = q_mem[rd_q];
	assign not_empty = cnt_q != '0;
	assign full      = cnt_q == (QPTR_W+1)'(QDEPTH);

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

[design/bffc_engine.sv]
// compensation engine: quadratic temperature, horner pressure sum over a shared
// limb multiplier, reciprocal divide by 100, saturation and the output register
// depends on bffc_pkg
module bffc_engine import bffc_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAL_W-1:0] cal,
	input  job_t             job,
	input  logic             job_valid,
	output logic             job_pop,
	output logic             res_valid,
	output res_item_t        res,
	input  logic             res_stall
);

	localparam int SHR       = DEN_BITS - OUT_FRAC_BITS;
	localparam int NUM_W     = 34;
	localparam int RCP_SH    = 41;
	localparam logic [34:0] RCP = 35'd21990232556;
	localparam logic [NUM_W-1:0] DIV_SAT =
		NUM_W'(longint'(PRESS_DIV) * (longint'(PRESS_MAX) + 1));
	localparam int TSH       = 48 - OUT_FRAC_BITS;
	localparam int MAC_LIMBS = 5;

	typedef enum logic [3:0] {
		E_IDLE, E_TLIN, E_COEF1, E_COEF2, E_COEF3, E_ABS, E_MAC, E_STEP,
		E_PDIV, E_DIV, E_SAT, E_PUT
	} st_t;

	st_t st_q;
	job_t job_q;

	// calibration coefficients
	logic [15:0]        par_t1, par_t2, par_p5, par_p6;
	logic signed [7:0]  par_t3, par_p3, par_p4, par_p7, par_p8, par_p10, par_p11;
	logic signed [15:0] par_p9;
	logic signed [16:0] par_p1, par_p2;

	assign par_t1  = cal[0+:16];
	assign par_t2  = cal[16+:16];
	assign par_t3  = cal[32+:8];
	assign par_p1  = 17'($signed(cal[40+:16])) - 17'sd16384;
	assign par_p2  = 17'($signed(cal[56+:16])) - 17'sd16384;
	assign par_p3  = cal[72+:8];
	assign par_p4  = cal[80+:8];
	assign par_p5  = cal[88+:16];
	assign par_p6  = cal[104+:16];
	assign par_p7  = cal[120+:8];
	assign par_p8  = cal[128+:8];
	assign par_p9  = cal[136+:16];
	assign par_p10 = cal[152+:8];
	assign par_p11 = cal[160+:8];

	logic signed [41:0] m1_q, c2u_q, c1u_q;
	logic signed [49:0] sq_q;
	logic [47:0]        u2_q, u3lo_q, u3hi_q;
	logic signed [32:0] a3m_q, b2m_q;
	logic signed [TL_W-1:0] tl_q;
	logic signed [64:0] s17u2_q;
	logic signed [56:0] s19u2_q;
	logic [71:0]        u3_q;
	logic signed [33:0] b2c_q;
	logic signed [62:0] b1c_q;
	logic signed [89:0] b0c_q;
	logic [59:0]        tmag_q;
	logic               tneg_q, pneg_q;
	logic [ACC_W-1:0]   x_q, mag_q, p_q;
	logic [2:0]         li_q;
	logic               dj_q;
	logic [1:0]         step_q;
	logic [NUM_W-1:0]   div_q;
	logic [51:0]        plo_q, phi_q;
	logic [23:0]        temp_q;
	logic [26:0]        press_q;
	res_item_t          res_q;
	logic               res_valid_q;

	logic signed [24:0] pd1, uu;
	logic signed [57:0] sqk;
	logic signed [59:0] m1s;
	logic [TL_W-1:0]    tl_abs, tq;
	logic signed [33:0] a3;
	logic signed [80:0] s20u3;
	logic [61:0]        pp;
	logic [7:0]         shamt;
	logic [ACC_W-1:0]   bsel;
	logic [68:0]        qsum;
	logic               out_free;

	always_comb begin
		pd1    = $signed({1'b0, job_q.raw_temp}) - $signed({1'b0, par_t1, 8'h00});
		uu     = $signed({1'b0, job_q.raw_press});
		sqk    = sq_q * par_t3;
		m1s    = {m1_q, 18'd0};
		tl_abs = tl_q[TL_W-1] ? TL_W'(-tl_q) : TL_W'(tl_q);
		tq     = tl_abs >> TSH;
		a3     = 34'($signed({par_p8, 22'd0})) + 34'(a3m_q);
		s20u3  = par_p11 * $signed({1'b0, u3_q});
		pp     = mag_q[{li_q, 5'b0} +: 32] * (dj_q ? tmag_q[59:30] : tmag_q[29:0]);
		shamt  = {li_q, 5'b0} + (dj_q ? 8'd30 : 8'd0);
		case (step_q)
			2'd0:    bsel = ACC_W'(b2c_q) << 53;
			2'd1:    bsel = ACC_W'(b1c_q) << 85;
			default: bsel = ACC_W'(b0c_q) << 116;
		endcase
		qsum  = 69'(plo_q) + {phi_q, 17'd0};
	end

	assign out_free  = !res_valid_q || !res_stall;
	assign job_pop   = (st_q == E_IDLE) && job_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= E_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (!res_stall && st_q != E_PUT) res_valid_q <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						temp_q  <= '0;
						press_q <= '0;
						st_q    <= job.comp ? E_TLIN : E_PUT;
					end
				end
				E_TLIN: begin
					m1_q  <= pd1 * $signed({1'b0, par_t2});
					sq_q  <= pd1 * pd1;
					u2_q  <= job_q.raw_press * job_q.raw_press;
					a3m_q <= par_p4 * uu;
					b2m_q <= par_p3 * uu;
					c2u_q <= par_p2 * uu;
					c1u_q <= par_p1 * uu;
					st_q  <= E_COEF1;
				end
				E_COEF1: begin
					tl_q    <= TL_W'(m1s) + TL_W'(sqk);
					u3lo_q  <= u2_q[23:0] * job_q.raw_press;
					u3hi_q  <= u2_q[47:24] * job_q.raw_press;
					s17u2_q <= par_p9 * $signed({1'b0, u2_q});
					s19u2_q <= par_p10 * $signed({1'b0, u2_q});
					st_q    <= E_COEF2;
				end
				E_COEF2: begin
					if (tl_q[TL_W-1])
						temp_q <= (tq > TL_W'(TEMP_MIN)) ? TEMP_MIN : 24'(-tq);
					else
						temp_q <= (tq > TL_W'(TEMP_MAX)) ? TEMP_MAX : tq[23:0];
					tmag_q <= tl_abs[59:0];
					tneg_q <= tl_q[TL_W-1];
					x_q    <= ACC_W'(a3);
					b2c_q  <= 34'($signed({par_p7, 24'd0})) + 34'(b2m_q);
					b1c_q  <= 63'({par_p6, 42'd0}) + 63'($signed({c2u_q, 19'd0}))
						+ 63'(s19u2_q);
					u3_q   <= 72'(u3lo_q) + {u3hi_q, 24'd0};
					st_q   <= E_COEF3;
				end
				E_COEF3: begin
					b0c_q  <= 90'({par_p5, 68'd0}) + 90'($signed({c1u_q, 45'd0}))
						+ 90'($signed({s17u2_q, 17'd0})) + 90'(s20u3);
					step_q <= '0;
					st_q   <= E_ABS;
				end
				E_ABS: begin
					mag_q  <= x_q[ACC_W-1] ? -x_q : x_q;
					pneg_q <= x_q[ACC_W-1] ^ tneg_q;
					p_q    <= '0;
					li_q   <= '0;
					dj_q   <= 1'b0;
					st_q   <= E_MAC;
				end
				E_MAC: begin
					p_q  <= p_q + (ACC_W'(pp) << shamt);
					dj_q <= ~dj_q;
					if (dj_q) begin
						li_q <= li_q + 3'd1;
						if (li_q == 3'(MAC_LIMBS - 1)) st_q <= E_STEP;
					end
				end
				E_STEP: begin
					x_q    <= pneg_q ? bsel - p_q : bsel + p_q;
					step_q <= step_q + 2'd1;
					st_q   <= (step_q == 2'd2) ? E_PDIV : E_ABS;
				end
				E_PDIV: begin
					if (x_q[ACC_W-1]) begin
						press_q <= '0;
						st_q    <= E_PUT;
					end else if ((x_q[ACC_W-1:SHR+NUM_W] != '0)
							|| (x_q[SHR+:NUM_W] >= DIV_SAT)) begin
						press_q <= PRESS_MAX;
						st_q    <= E_PUT;
					end else begin
						div_q <= x_q[SHR+:NUM_W];
						st_q  <= E_DIV;
					end
				end
				E_DIV: begin
					plo_q <= div_q[16:0] * RCP;
					phi_q <= div_q[33:17] * RCP;
					st_q  <= E_SAT;
				end
				E_SAT: begin
					press_q <= qsum[RCP_SH +: 27];
					st_q    <= E_PUT;
				end
				E_PUT: begin
					if (out_free) begin
						res_q.reading_valid   <= job_q.comp;
						res_q.temperature_q16 <= temp_q;
						res_q.pressure_q16    <= press_q;
						res_q.reading_index   <= job_q.index;
						res_q.burst_end       <= job_q.burst_end;
						res_q.reading_total   <= job_q.total;
						res_valid_q           <= 1'b1;
						st_q                  <= E_IDLE;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

endmodule

[design/baro_fifo_frame_compensator_unit.sv]
// Bytes of a sensor fifo burst enter one per cycle on the fifo channel while the four-entry
// job queue has room; the parser never holds a byte longer than that. Each completed frame
// with a nonzero raw value becomes one reading, computed by the engine in three Horner steps
// over a 32 by 30 bit limb multiplier, and the division by 100 is a reciprocal multiplication
// split into low and high partial products. A negative or saturated pressure skips that
// multiplication, and a result that only closes a burst goes from the queue head straight to
// the output state. Sustained frame rate is therefore one reading per engine pass; the queue
// absorbs short bursts of frames. The user must write calibration and max_readings through
// the cfg port only while idle; the block itself does not enforce this.
module baro_fifo_frame_compensator_unit import bffc_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	parameter int READING_LIMIT = READING_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fifo_valid,
	output logic        fifo_stall,
	input  fifo_item_t  fifo_item,
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [CAL_W-1:0] cal_q;
	logic [10:0]      max_rd_q;
	logic             take, push, pop, not_empty, full;
	job_t             job_in, job_out;

	assign cfg_ready  = 1'b1;
	assign fifo_stall = full;
	assign take       = fifo_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= '0;
			max_rd_q <= MAX_READINGS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CAL_LO:       cal_q[63:0]    <= cfg_data;
				CFG_CAL_MID:      cal_q[127:64]  <= cfg_data;
				CFG_CAL_HI:       cal_q[167:128] <= cfg_data[39:0];
				CFG_MAX_READINGS: max_rd_q       <= cfg_data[10:0];
			endcase
		end
	end

	bffc_front #(
		.READING_LIMIT(READING_LIMIT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (fifo_item),
		.take        (take),
		.max_readings(max_rd_q),
		.push        (push),
		.job         (job_in)
	);

	bffc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.job_in   (job_in),
		.pop      (pop),
		.job_out  (job_out),
		.not_empty(not_empty),
		.full     (full)
	);

	bffc_engine #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal_q),
		.job      (job_out),
		.job_valid(not_empty),
		.job_pop  (pop),
		.res_valid(res_valid),
		.res      (res_item),
		.res_stall(res_stall)
	);

endmodule
